// ===== rtl/core/c2c_pkg.sv =====
// ----------------------------------------------------------------------------
// c2c_pkg
// Shared constants, codes and controller/datapath interface types for the
// covariance-to-correlation block.
// ----------------------------------------------------------------------------
`default_nettype none

package c2c_pkg;

  localparam int MAX_DIM_DEF = 32;

  localparam int IDX_W  = 5;
  localparam int VAL_W  = 32;
  localparam int CORR_W = 16;

  localparam int ONE_Q14  = 16384;
  localparam int FRAC_W   = 14;
  localparam int QUO_W    = FRAC_W + 1;

  // Variances are positive 31-bit values, so their product is below 2**62.
  localparam int VAR_W    = VAL_W - 1;
  localparam int PROD_W   = 2 * VAR_W;
  localparam int ROOT_W   = VAR_W;
  localparam int REM_W    = VAL_W + 1;

  localparam int SQRT_STEPS = PROD_W / 2;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Which stored entry the datapath addresses.
  localparam logic [1:0] SEL_COV = 2'd0;
  localparam logic [1:0] SEL_VLO = 2'd1;
  localparam logic [1:0] SEL_VHI = 2'd2;

  // Kind of result loaded into the output registers.
  localparam logic [1:0] RES_ERR  = 2'd0;
  localparam logic [1:0] RES_ONE  = 2'd1;
  localparam logic [1:0] RES_CALC = 2'd2;

  typedef struct packed {
    logic       write;
    logic       load;
    logic [1:0] rd_sel;
    logic       cap_cov;
    logic       cap_vlo;
    logic       cap_vhi;
    logic       mul;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       fin;
    logic [1:0] fin_kind;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic diag;
    logic bad_var;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/c2c_ram.sv =====
// ----------------------------------------------------------------------------
// c2c_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module c2c_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/c2c_ctrl.sv =====
// ----------------------------------------------------------------------------
// c2c_ctrl
// Sequencer for the correlation read: classifies the request, fetches the
// three stored entries, then runs the square root and the divider unless the read ends early.
// ----------------------------------------------------------------------------
`default_nettype none

module c2c_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_operation,
  input  wire c2c_pkg::stat_t stat,
  output      c2c_pkg::cmd_t cmd,
  output      logic          busy,
  output      logic          out_valid
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLASS  = 4'd1;
  localparam logic [3:0] S_RD_COV = 4'd2;
  localparam logic [3:0] S_RD_VLO = 4'd3;
  localparam logic [3:0] S_RD_VHI = 4'd4;
  localparam logic [3:0] S_CAP    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_SQRT   = 4'd7;
  localparam logic [3:0] S_DIVI   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0]                   state_r, state_nxt;
  logic [c2c_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.rd_sel    = c2c_pkg::SEL_COV;
    cmd.fin_kind  = c2c_pkg::RES_CALC;

    unique case (state_r)
      S_IDLE: begin
        cmd.write = accept && (in_operation == c2c_pkg::OP_WRITE);
        cmd.load  = accept && (in_operation == c2c_pkg::OP_READ);
        if (cmd.load) begin
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat.oor) begin
          cmd.fin      = 1'b1;
          cmd.fin_kind = c2c_pkg::RES_ERR;
          state_nxt    = S_IDLE;
        end else if (stat.diag) begin
          cmd.fin      = 1'b1;
          cmd.fin_kind = c2c_pkg::RES_ONE;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_RD_COV;
        end
      end
      S_RD_COV: begin
        cmd.rd_sel = c2c_pkg::SEL_COV;
        state_nxt  = S_RD_VLO;
      end
      S_RD_VLO: begin
        cmd.rd_sel  = c2c_pkg::SEL_VLO;
        cmd.cap_cov = 1'b1;
        state_nxt   = S_RD_VHI;
      end
      S_RD_VHI: begin
        cmd.rd_sel  = c2c_pkg::SEL_VHI;
        cmd.cap_vlo = 1'b1;
        state_nxt   = S_CAP;
      end
      S_CAP: begin
        cmd.cap_vhi = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        if (stat.bad_var) begin
          cmd.fin      = 1'b1;
          cmd.fin_kind = c2c_pkg::RES_ERR;
          state_nxt    = S_IDLE;
        end else begin
          cmd.mul   = 1'b1;
          cnt_nxt   = c2c_pkg::CNT_W'(c2c_pkg::SQRT_STEPS - 1);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = c2c_pkg::CNT_W'(c2c_pkg::DIV_STEPS - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin      = 1'b1;
        cmd.fin_kind = c2c_pkg::RES_CALC;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = cmd.fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/c2c_dp.sv =====
// ----------------------------------------------------------------------------
// c2c_dp
// Datapath: index handling, store addressing, variance product, bit-pair
// integer square root, bit-serial divider and result formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module c2c_dp #(
  parameter int MAX_DIM = c2c_pkg::MAX_DIM_DEF
) (
  input  wire logic                                    clk,
  input  wire c2c_pkg::cmd_t                           cmd,
  output      c2c_pkg::stat_t                          stat,
  input  wire logic [c2c_pkg::IDX_W-1:0]               in_row,
  input  wire logic [c2c_pkg::IDX_W-1:0]               in_col,
  input  wire logic signed [c2c_pkg::VAL_W-1:0]        in_value,
  output      logic                                    ram_we,
  output      logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      ram_waddr,
  output      logic [c2c_pkg::VAL_W-1:0]               ram_wdata,
  output      logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      ram_raddr,
  input  wire logic [c2c_pkg::VAL_W-1:0]               ram_rdata,
  output      logic signed [c2c_pkg::CORR_W-1:0]       out_correlation,
  output      logic                                    out_status
);

  localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
  localparam int IDX_W  = c2c_pkg::IDX_W;
  localparam int VAL_W  = c2c_pkg::VAL_W;
  localparam int PROD_W = c2c_pkg::PROD_W;
  localparam int ROOT_W = c2c_pkg::ROOT_W;
  localparam int REM_W  = c2c_pkg::REM_W;
  localparam int QUO_W  = c2c_pkg::QUO_W;
  localparam int CORR_W = c2c_pkg::CORR_W;

  localparam logic [PROD_W-1:0] SQRT_BIT0 = PROD_W'(1) << (PROD_W - 2);
  localparam logic [QUO_W-1:0]  ONE_Q     = QUO_W'(c2c_pkg::ONE_Q14);

  logic [IDX_W-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic                    oor_r, oor_nxt, diag_r, diag_nxt;
  logic signed [VAL_W-1:0] cov_r, cov_nxt, vlo_r, vlo_nxt, vhi_r, vhi_nxt;
  logic [PROD_W-1:0]       x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]        q_r, q_nxt;
  logic                    sat_r, sat_nxt;
  logic signed [CORR_W-1:0] corr_r, corr_nxt;
  logic                    status_r, status_nxt;

  logic                    row_ok, col_ok;
  logic [PROD_W:0]         sq_sum;
  logic                    sq_ge;
  logic [ROOT_W-1:0]       root;
  logic                    neg;
  logic [VAL_W-1:0]        mag;
  logic                    div_ge;
  logic [REM_W-1:0]        div_diff;
  logic [QUO_W-1:0]        q_mag;
  logic [CORR_W-1:0]       q_ext;

  assign row_ok = (32'(in_row) < MAX_DIM);
  assign col_ok = (32'(in_col) < MAX_DIM);

  assign ram_we    = cmd.write && row_ok && col_ok;
  assign ram_waddr = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign ram_wdata = in_value;

  always_comb begin
    case (cmd.rd_sel)
      c2c_pkg::SEL_VLO: ram_raddr = AW'(32'(lo_r) * MAX_DIM + 32'(lo_r));
      c2c_pkg::SEL_VHI: ram_raddr = AW'(32'(hi_r) * MAX_DIM + 32'(hi_r));
      default:          ram_raddr = AW'(32'(lo_r) * MAX_DIM + 32'(hi_r));
    endcase
  end

  assign stat.oor     = oor_r;
  assign stat.diag    = diag_r;
  assign stat.bad_var = (vlo_r <= 0) || (vhi_r <= 0);

  // One pair of product bits per step; res converges to the floor root.
  assign sq_sum = {1'b0, res_r} + {1'b0, bit_r};
  assign sq_ge  = ({1'b0, x_r} >= sq_sum);
  assign root   = res_r[ROOT_W-1:0];

  assign neg      = cov_r[VAL_W-1];
  assign mag      = neg ? (VAL_W'(0) - VAL_W'(cov_r)) : VAL_W'(cov_r);
  assign div_ge   = (rem_r >= REM_W'(root));
  assign div_diff = rem_r - REM_W'(root);

  assign q_mag = (sat_r || (q_r > ONE_Q)) ? ONE_Q : q_r;
  assign q_ext = CORR_W'(q_mag);

  always_comb begin
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    oor_nxt    = oor_r;
    diag_nxt   = diag_r;
    cov_nxt    = cov_r;
    vlo_nxt    = vlo_r;
    vhi_nxt    = vhi_r;
    x_nxt      = x_r;
    res_nxt    = res_r;
    bit_nxt    = bit_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    sat_nxt    = sat_r;
    corr_nxt   = corr_r;
    status_nxt = status_r;

    if (cmd.load) begin
      lo_nxt   = (in_row < in_col) ? in_row : in_col;
      hi_nxt   = (in_row < in_col) ? in_col : in_row;
      oor_nxt  = !(row_ok && col_ok);
      diag_nxt = (in_row == in_col);
    end
    if (cmd.cap_cov) begin
      cov_nxt = ram_rdata;
    end
    if (cmd.cap_vlo) begin
      vlo_nxt = ram_rdata;
    end
    if (cmd.cap_vhi) begin
      vhi_nxt = ram_rdata;
    end
    if (cmd.mul) begin
      x_nxt   = vlo_r[VAL_W-2:0] * vhi_r[VAL_W-2:0];
      res_nxt = '0;
      bit_nxt = SQRT_BIT0;
    end
    if (cmd.sqrt_step) begin
      if (sq_ge) begin
        x_nxt   = x_r - sq_sum[PROD_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
    if (cmd.div_init) begin
      // A magnitude of twice the root or more always saturates.
      sat_nxt = ({1'b0, mag} >= {1'b0, root, 1'b0});
      rem_nxt = {1'b0, mag};
      q_nxt   = '0;
    end
    if (cmd.div_step) begin
      q_nxt   = {q_r[QUO_W-2:0], div_ge};
      rem_nxt = (div_ge ? div_diff : rem_r) << 1;
    end
    if (cmd.fin) begin
      case (cmd.fin_kind)
        c2c_pkg::RES_ONE: begin
          corr_nxt   = CORR_W'(c2c_pkg::ONE_Q14);
          status_nxt = 1'b0;
        end
        c2c_pkg::RES_CALC: begin
          corr_nxt   = neg ? (CORR_W'(0) - q_ext) : q_ext;
          status_nxt = 1'b0;
        end
        default: begin
          corr_nxt   = '0;
          status_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    oor_r    <= oor_nxt;
    diag_r   <= diag_nxt;
    cov_r    <= cov_nxt;
    vlo_r    <= vlo_nxt;
    vhi_r    <= vhi_nxt;
    x_r      <= x_nxt;
    res_r    <= res_nxt;
    bit_r    <= bit_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    sat_r    <= sat_nxt;
    corr_r   <= corr_nxt;
    status_r <= status_nxt;
  end

  assign out_correlation = corr_r;
  assign out_status      = status_r;

endmodule

`default_nettype wire

// ===== rtl/core/covariance_to_correlation_unit.sv =====
// ----------------------------------------------------------------------------
// covariance_to_correlation_unit
// Covariance matrix store that answers correlation reads in signed Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken when start is high and busy is low. With
//   in_operation at write, in_value is stored at (in_row, in_col) in that
//   same cycle; busy stays low, so writes can be issued every cycle and give
//   no result. Indexes at or beyond MAX_DIM make a write do nothing.
//   With in_operation at read, busy rises and one result word follows:
//   out_valid is high for exactly one cycle with out_correlation and
//   out_status. A diagonal or out-of-range read answers straight from the
//   classify step; a read with a non-positive variance answers once its three
//   entries are captured; a full read answers after the three sequential
//   store reads, the 31-step square root of the variance product and the
//   15-step divider. Busy drops in the cycle that the result is shown, so
//   the next command can be taken then.
//   Results cannot be held off; the receiver must take each one as shown.
//   Reset (synchronous, active low) returns the sequencer to idle; the
//   store is not cleared, and only entries already written may be read.
// ----------------------------------------------------------------------------
`default_nettype none

module covariance_to_correlation_unit #(
  parameter int MAX_DIM = c2c_pkg::MAX_DIM_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire logic                               in_operation,
  input  wire logic [c2c_pkg::IDX_W-1:0]          in_row,
  input  wire logic [c2c_pkg::IDX_W-1:0]          in_col,
  input  wire logic signed [c2c_pkg::VAL_W-1:0]   in_value,
  output      logic                               out_valid,
  output      logic signed [c2c_pkg::CORR_W-1:0]  out_correlation,
  output      logic                               out_status
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  c2c_pkg::cmd_t              cmd;
  c2c_pkg::stat_t             stat;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [c2c_pkg::VAL_W-1:0]  ram_wdata, ram_rdata;

  c2c_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  c2c_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .stat            (stat),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_correlation (out_correlation),
    .out_status      (out_status)
  );

  c2c_ram #(
    .WIDTH (c2c_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/c2c_checker.sv =====
// ----------------------------------------------------------------------------
// c2c_checker
// Port-level checks of the command and result behavior, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module c2c_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              in_operation,
  input wire logic                              out_valid,
  input wire logic signed [c2c_pkg::CORR_W-1:0] out_correlation,
  input wire logic                              out_status
);

  // A result word is only shown once the sequencer is back to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Writes complete at once and never produce a result word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == c2c_pkg::OP_WRITE)) |=> (!busy && !out_valid))
    else $error("write word left the block busy or gave a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == c2c_pkg::OP_READ)) |=> busy)
    else $error("read word did not start the sequencer");

  // An error result carries zero; a good one stays within plus or minus one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status && (out_correlation == '0)) ||
                   (!out_status && (out_correlation <= 16'sd16384) &&
                    (out_correlation >= -16'sd16384))))
    else $error("result word out of range");

endmodule

bind covariance_to_correlation_unit c2c_checker u_c2c_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_correlation (out_correlation),
  .out_status      (out_status)
);

`default_nettype wire

// ===== sim/covariance_to_correlation_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// covariance_to_correlation_unit_tb
// Self-checking bench for the covariance store and correlation reader.
// Fills the store with command words and reads correlation entries back in
// Q1.14. A directed table covers the diagonal, mirrored lower reads,
// saturation at both signs, zero and negative variances and the index
// corners. It is followed by random write/read sequences that only read
// entries already written. Reads are predicted from a shadow copy of the matrix
// or taken from the table, then checked field by field against strobed results.
// ----------------------------------------------------------------------------

module covariance_to_correlation_unit_tb;

  localparam int DIM          = c2c_pkg::MAX_DIM_DEF;
  localparam int IDX_W        = c2c_pkg::IDX_W;
  localparam int VAL_W        = c2c_pkg::VAL_W;
  localparam int CORR_W       = c2c_pkg::CORR_W;
  localparam int FRAC_W       = c2c_pkg::FRAC_W;
  localparam int ONE_Q14      = c2c_pkg::ONE_Q14;
  localparam int RANDOM_WORDS = 1200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_BAD_VAR = 1'b1;

  typedef struct packed {
    logic signed [CORR_W-1:0] corr;
    logic                     status;
  } corr_word_t;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    corr_word_t              want;
  } directed_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_operation;
  logic [IDX_W-1:0]         in_row;
  logic [IDX_W-1:0]         in_col;
  logic signed [VAL_W-1:0]  in_value;
  logic                     out_valid;
  logic signed [CORR_W-1:0] out_correlation;
  logic                     out_status;

  // Shadow of the matrix, plus a map of which entries have been written.
  logic signed [VAL_W-1:0] shadow_cov [0:DIM-1][0:DIM-1];
  bit                      cov_written [0:DIM-1][0:DIM-1];

  corr_word_t    pending_corr_q [$];
  directed_row_t directed_q [$];

  int errors;
  int stall_cycles;
  int sender_idle_pct;

  covariance_to_correlation_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_correlation (out_correlation),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_sqrt64(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic corr_word_t predict_correlation(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
    logic [IDX_W-1:0]        lo;
    logic [IDX_W-1:0]        hi;
    logic signed [VAL_W-1:0] cov;
    logic signed [VAL_W-1:0] var_lo;
    logic signed [VAL_W-1:0] var_hi;
    logic [VAL_W-1:0]        mag;
    logic [63:0]             root;
    logic [63:0]             quot;
    corr_word_t              res;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    cov    = shadow_cov[lo][hi];
    var_lo = shadow_cov[lo][lo];
    var_hi = shadow_cov[hi][hi];
    res.status = ST_OK;
    if (r == c) begin
      res.corr = CORR_W'(ONE_Q14);
    end else if (var_lo <= 0 || var_hi <= 0) begin
      res.corr   = '0;
      res.status = ST_BAD_VAR;
    end else begin
      root = floor_sqrt64({32'd0, var_lo} * {32'd0, var_hi});
      mag  = cov[VAL_W-1] ? (~cov + 32'd1) : cov;
      quot = ({32'd0, mag} << FRAC_W) / root;
      if (quot > 64'(ONE_Q14)) quot = 64'(ONE_Q14);
      res.corr = cov[VAL_W-1] ? (16'd0 - quot[15:0]) : quot[15:0];
    end
    return res;
  endfunction

  // Variances are mostly positive with a spread of magnitudes. Upper
  // covariances are often a fraction of the geometric mean so that the
  // quotient mostly lands inside the unit range instead of saturating.
  function automatic logic signed [VAL_W-1:0] pick_value(input logic [IDX_W-1:0] r,
                                                         input logic [IDX_W-1:0] c);
    logic [63:0]             root;
    logic [63:0]             scaled;
    logic signed [VAL_W-1:0] v;
    v = $signed($urandom) >>> $urandom_range(0, 31);
    if (r == c) begin
      case ($urandom_range(0, 15))
        0:       v = '0;
        1:       v = {1'b1, 31'($urandom)};
        2:       v = -32'sd1;
        default: v = $signed($urandom >> $urandom_range(1, 31));
      endcase
    end else if (r < c && cov_written[r][r] && cov_written[c][c] &&
                 shadow_cov[r][r] > 0 && shadow_cov[c][c] > 0 &&
                 $urandom_range(0, 9) < 6) begin
      root   = floor_sqrt64({32'd0, shadow_cov[r][r]} * {32'd0, shadow_cov[c][c]});
      scaled = (root * $urandom_range(0, 18)) >> 4;
      if (scaled > 64'h7fff_ffff) scaled = 64'h7fff_ffff;
      v = $urandom_range(0, 1) ? -$signed(scaled[31:0]) : $signed(scaled[31:0]);
    end
    return v;
  endfunction

  // Holds the word on the ports until the block takes it; start is decided
  // afresh each cycle, so idle gaps land on every phase of a read.
  task automatic issue_word(input logic op, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v,
                            input logic typed, input corr_word_t want);
    logic go;
    do begin
      go = ($urandom_range(0, 99) >= sender_idle_pct);
      start        <= go;
      in_operation <= op;
      in_row       <= r;
      in_col       <= c;
      in_value     <= v;
      @(posedge clk);
    end while (!(go && !busy));
    if (op == c2c_pkg::OP_WRITE) begin
      shadow_cov[r][c]  = v;
      cov_written[r][c] = 1'b1;
    end else begin
      pending_corr_q.push_back(typed ? want : predict_correlation(r, c));
    end
  endtask

  task automatic add_row(input logic op, input int r, input int c, input int v,
                         input int typed, input int corr, input logic status);
    directed_row_t row;
    row.op          = op;
    row.row         = IDX_W'(r);
    row.col         = IDX_W'(c);
    row.value       = v;
    row.typed       = (typed != 0);
    row.want.corr   = CORR_W'(corr);
    row.want.status = status;
    directed_q.push_back(row);
  endtask

  // Picks the next random word. A read whose operands are not all in the
  // store turns into the write that supplies the first missing one.
  task automatic next_random_word(output logic op, output logic [IDX_W-1:0] r,
                                  output logic [IDX_W-1:0] c,
                                  output logic signed [VAL_W-1:0] v);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] t;
    if ($urandom_range(0, 9) < 7) begin
      r = IDX_W'($urandom_range(0, 7));
      c = IDX_W'($urandom_range(0, 7));
    end else begin
      r = IDX_W'($urandom_range(0, DIM - 1));
      c = IDX_W'($urandom_range(0, DIM - 1));
    end
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    if ($urandom_range(0, 99) < 55) begin
      op = c2c_pkg::OP_WRITE;
      if (!cov_written[lo][lo]) begin
        r = lo; c = lo;
      end else if (!cov_written[hi][hi]) begin
        r = hi; c = hi;
      end else if (!cov_written[lo][hi]) begin
        r = lo; c = hi;
      end else begin
        op = c2c_pkg::OP_READ;
      end
      v = (op == c2c_pkg::OP_READ) ? $signed($urandom) : pick_value(r, c);
    end else begin
      op = c2c_pkg::OP_WRITE;
      // Lower-triangle writes are stored but never read; keep a few.
      if (r > c && $urandom_range(0, 3) != 0) begin
        t = r; r = c; c = t;
      end
      v = pick_value(r, c);
    end
  endtask

  always @(posedge clk) begin
    corr_word_t head;
    if (rst_n && out_valid) begin
      if (pending_corr_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual correlation %0d status %0d",
                 $time, out_correlation, out_status);
      end else begin
        head = pending_corr_q.pop_front();
        if (out_correlation !== head.corr) begin
          errors++;
          $display("%0t: correlation mismatch, expected %0d actual %0d",
                   $time, head.corr, out_correlation);
        end
        if (out_status !== head.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, head.status, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic                    op;
    logic [IDX_W-1:0]        r;
    logic [IDX_W-1:0]        c;
    logic signed [VAL_W-1:0] v;
    directed_row_t           row;
    errors          = 0;
    stall_cycles    = 0;
    sender_idle_pct = 32;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= c2c_pkg::OP_WRITE;
    in_row       <= '0;
    in_col       <= '0;
    in_value     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(c2c_pkg::OP_WRITE, 0, 0, 4, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 1, 1, 9, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 0, 1, 6, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 0, 1, 0, 1, ONE_Q14, ST_OK);
    add_row(c2c_pkg::OP_READ, 1, 0, -1, 1, ONE_Q14, ST_OK);
    add_row(c2c_pkg::OP_READ, 0, 0, 0, 1, ONE_Q14, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 0, 1, 32'h8000_0000, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 1, 0, 0, 1, -ONE_Q14, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 0, 1, 32'h7fff_ffff, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 0, 1, 0, 1, ONE_Q14, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 2, 2, 0, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 0, 2, 5, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 2, 0, 0, 1, 0, ST_BAD_VAR);
    add_row(c2c_pkg::OP_WRITE, 3, 3, -1, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 0, 3, 7, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 0, 3, 0, 1, 0, ST_BAD_VAR);
    add_row(c2c_pkg::OP_WRITE, 3, 3, 32'h8000_0000, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 3, 0, 0, 1, 0, ST_BAD_VAR);
    add_row(c2c_pkg::OP_WRITE, 0, 1, 0, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 0, 1, 0, 1, 0, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 31, 31, 32'h7fff_ffff, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 0, 31, -3, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 31, 0, 0, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 30, 30, 32'h7fff_ffff, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_WRITE, 30, 31, 32'h7fff_ffff, 0, 0, ST_OK);
    add_row(c2c_pkg::OP_READ, 31, 30, 32'hffff_ffff, 1, ONE_Q14, ST_OK);
    add_row(c2c_pkg::OP_READ, 31, 31, 0, 1, ONE_Q14, ST_OK);

    foreach (directed_q[i]) begin
      row = directed_q[i];
      issue_word(row.op, row.row, row.col, row.value, row.typed, row.want);
    end

    // Sender idles about a third of the time, then two thirds, then never.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) sender_idle_pct = 67;
      if (n == 2 * RANDOM_WORDS / 3) sender_idle_pct = 0;
      next_random_word(op, r, c, v);
      issue_word(op, r, c, v, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_corr_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
